### sv/tts_pkg.sv
// Package for the touch tap/swipe classifier: coordinate widths, register
// indexes, reset values and the gesture kind codes.
// No dependencies.
`default_nettype none

package tts_pkg;

  // Default coordinate widths
  localparam int unsigned X_BITS_DEF = 11;
  localparam int unsigned Y_BITS_DEF = 10;

  // Configuration register width and reset values
  localparam int unsigned CFG_BITS      = 11;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam logic [CFG_BITS-1:0] TAP_LIMIT_RST = 11'd28;
  localparam logic [CFG_BITS-1:0] SWIPE_MIN_RST = 11'd90;
  localparam logic [2*CFG_BITS-1:0] TAP_SQ_RST =
    (2*CFG_BITS)'(TAP_LIMIT_RST) * (2*CFG_BITS)'(TAP_LIMIT_RST);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_LIMIT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SWIPE_MIN = 1'd1;

  // Reported gesture kinds
  typedef enum logic [2:0] {
    KIND_TAP   = 3'd0,
    KIND_LEFT  = 3'd1,
    KIND_RIGHT = 3'd2,
    KIND_UP    = 3'd3,
    KIND_DOWN  = 3'd4
  } gesture_kind_e;

endpackage

`default_nettype wire

### sv/touch_tap_swipe_classifier_top.sv
// Touch tap/swipe classifier: tracks one touch from press to lift, hands out
// drag deltas and classifies the completed gesture.
// Depends on tts_pkg.
// The result of a frame is registered on its acceptance and presented in the next cycle.
// One frame per cycle; the single output register is the only
// buffer, so a frame is taken whenever that register is empty or drained.
// The squared travel of a move is registered and folded into the peak on the
// next frame, which also serves a lift in the very next cycle.
// Reset: asynchronous, active low; clears tracking, the output valid and
// loads the threshold registers with their defaults (tap 28, swipe 90).
`default_nettype none

module touch_tap_swipe_classifier_top
  import tts_pkg::*;
#(
  parameter int unsigned X_BITS = X_BITS_DEF,
  parameter int unsigned Y_BITS = Y_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_BITS-1:0]      cfg_data_i,
  // frame input channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     finger_down_i,
  input  wire logic [X_BITS-1:0]        touch_x_i,
  input  wire logic [Y_BITS-1:0]        touch_y_i,
  input  wire logic                     take_drag_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          gesture_valid_o,
  output logic [2:0]                    gesture_kind_o,
  output logic [X_BITS-1:0]             gesture_start_x_o,
  output logic [Y_BITS-1:0]             gesture_start_y_o,
  output logic signed [X_BITS:0]        gesture_dx_o,
  output logic signed [Y_BITS:0]        gesture_dy_o,
  output logic                          drag_valid_o,
  output logic signed [X_BITS:0]        drag_dx_o,
  output logic signed [Y_BITS:0]        drag_dy_o
);

  localparam int unsigned MW  = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int unsigned CW  = (MW > CFG_BITS) ? MW : CFG_BITS;
  localparam int unsigned PW  = 2 * X_BITS;
  localparam int unsigned SW  = 2 * MW + 1;
  localparam int unsigned TW  = 2 * CFG_BITS;
  localparam int unsigned PKW = (PW > TW) ? PW : TW;

  // Configuration registers
  logic [CFG_BITS-1:0] swipe_min_q;
  logic [TW-1:0]       tap_sq_q;

  // Tracking state
  logic                tracking_q, tracking_d;
  logic [X_BITS-1:0]   origin_x_q, origin_x_d, prev_x_q, prev_x_d;
  logic [Y_BITS-1:0]   origin_y_q, origin_y_d, prev_y_q, prev_y_d;
  logic [X_BITS:0]     pend_dx_q, pend_dx_d;
  logic [Y_BITS:0]     pend_dy_q, pend_dy_d;
  logic [PW-1:0]       peak_q, peak_d, d2_q, d2_d;
  logic                d2v_q, d2v_d;

  // Output register
  logic                out_valid_q;
  logic                g_valid_q, g_valid_d;
  gesture_kind_e       g_kind_q, g_kind_d;
  logic [X_BITS-1:0]   g_sx_q, g_sx_d;
  logic [Y_BITS-1:0]   g_sy_q, g_sy_d;
  logic [X_BITS:0]     g_dx_q, g_dx_d;
  logic [Y_BITS:0]     g_dy_q, g_dy_d;
  logic                d_valid_q, d_valid_d;
  logic [X_BITS:0]     d_dx_q, d_dx_d;
  logic [Y_BITS:0]     d_dy_q, d_dy_d;

  logic in_accept, cfg_accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;

  // Offset of the current touch from the start point and its squared length
  logic [X_BITS:0]   ox, pdx_mv;
  logic [Y_BITS:0]   oy, pdy_mv;
  logic [X_BITS-1:0] ox_mag;
  logic [Y_BITS-1:0] oy_mag;
  logic [2*X_BITS-1:0] sq_x;
  logic [2*Y_BITS-1:0] sq_y;
  logic [SW-1:0]     d2_sum;
  logic [PW-1:0]     d2_sat;

  assign ox     = {1'b0, touch_x_i} - {1'b0, origin_x_q};
  assign oy     = {1'b0, touch_y_i} - {1'b0, origin_y_q};
  assign ox_mag = ox[X_BITS] ? X_BITS'(-ox) : ox[X_BITS-1:0];
  assign oy_mag = oy[Y_BITS] ? Y_BITS'(-oy) : oy[Y_BITS-1:0];
  assign sq_x   = ox_mag * ox_mag;
  assign sq_y   = oy_mag * oy_mag;
  assign d2_sum = SW'(sq_x) + SW'(sq_y);
  assign d2_sat = ((d2_sum >> PW) != '0) ? {PW{1'b1}} : PW'(d2_sum);

  // Accumulate the pending drag with this frame's movement
  assign pdx_mv = pend_dx_q + {1'b0, touch_x_i} - {1'b0, prev_x_q};
  assign pdy_mv = pend_dy_q + {1'b0, touch_y_i} - {1'b0, prev_y_q};

  // Peak including the squared travel still held from the last move
  logic [PW-1:0] peak_eff;
  assign peak_eff = (d2v_q && (d2_q > peak_q)) ? d2_q : peak_q;

  // Classify the completed gesture from the last position
  logic [X_BITS:0]   gdx;
  logic [Y_BITS:0]   gdy;
  logic [X_BITS-1:0] gax;
  logic [Y_BITS-1:0] gay;
  logic              is_tap, ax_ge_ay, x_swipe, y_swipe;
  gesture_kind_e     lift_kind;

  assign gdx      = {1'b0, prev_x_q} - {1'b0, origin_x_q};
  assign gdy      = {1'b0, prev_y_q} - {1'b0, origin_y_q};
  assign gax      = gdx[X_BITS] ? X_BITS'(-gdx) : gdx[X_BITS-1:0];
  assign gay      = gdy[Y_BITS] ? Y_BITS'(-gdy) : gdy[Y_BITS-1:0];
  assign is_tap   = PKW'(peak_eff) < PKW'(tap_sq_q);
  assign ax_ge_ay = CW'(gax) >= CW'(gay);
  assign x_swipe  = ax_ge_ay && (CW'(gax) >= CW'(swipe_min_q));
  assign y_swipe  = !ax_ge_ay && (CW'(gay) >= CW'(swipe_min_q));

  always_comb begin
    if (is_tap) begin
      lift_kind = KIND_TAP;
    end else if (x_swipe) begin
      lift_kind = gdx[X_BITS] ? KIND_LEFT : KIND_RIGHT;
    end else if (y_swipe) begin
      lift_kind = gdy[Y_BITS] ? KIND_UP : KIND_DOWN;
    end else begin
      lift_kind = KIND_TAP;
    end
  end

  // Next state and result for the frame at the input
  logic [X_BITS:0] pdx_nx;
  logic [Y_BITS:0] pdy_nx;
  logic            drag_fire;

  always_comb begin
    tracking_d = tracking_q;
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    pdx_nx     = pend_dx_q;
    pdy_nx     = pend_dy_q;
    peak_d     = peak_q;
    d2_d       = d2_q;
    d2v_d      = d2v_q;
    g_valid_d  = 1'b0;
    g_kind_d   = KIND_TAP;
    g_sx_d     = '0;
    g_sy_d     = '0;
    g_dx_d     = '0;
    g_dy_d     = '0;

    if (finger_down_i) begin
      if (!tracking_q) begin
        // press: record the start point
        tracking_d = 1'b1;
        origin_x_d = touch_x_i;
        origin_y_d = touch_y_i;
        prev_x_d   = touch_x_i;
        prev_y_d   = touch_y_i;
        pdx_nx     = '0;
        pdy_nx     = '0;
        peak_d     = '0;
        d2v_d      = 1'b0;
      end else begin
        // move: advance the drag and fold the held travel into the peak
        prev_x_d = touch_x_i;
        prev_y_d = touch_y_i;
        pdx_nx   = pdx_mv;
        pdy_nx   = pdy_mv;
        peak_d   = peak_eff;
        d2_d     = d2_sat;
        d2v_d    = 1'b1;
      end
    end else if (tracking_q) begin
      // lift: report the gesture and drop the drag and the held travel
      tracking_d = 1'b0;
      d2v_d      = 1'b0;
      pdx_nx     = '0;
      pdy_nx     = '0;
      g_valid_d  = 1'b1;
      g_kind_d   = lift_kind;
      g_sx_d     = origin_x_q;
      g_sy_d     = origin_y_q;
      g_dx_d     = gdx;
      g_dy_d     = gdy;
    end

    // hand out the pending drag after the touch is processed
    drag_fire = take_drag_i && tracking_d && ((pdx_nx != '0) || (pdy_nx != '0));
    d_valid_d = drag_fire;
    d_dx_d    = drag_fire ? pdx_nx : '0;
    d_dy_d    = drag_fire ? pdy_nx : '0;
    pend_dx_d = drag_fire ? '0 : pdx_nx;
    pend_dy_d = drag_fire ? '0 : pdy_nx;
  end

  // Configuration registers; the tap limit is kept squared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_sq_q    <= TAP_SQ_RST;
      swipe_min_q <= SWIPE_MIN_RST;
    end else if (cfg_accept) begin
      case (cfg_index_i)
        REG_TAP_LIMIT: begin
          tap_sq_q    <= TW'(cfg_data_i) * TW'(cfg_data_i);
        end
        REG_SWIPE_MIN: begin
          swipe_min_q <= cfg_data_i;
        end
        default: begin
          tap_sq_q    <= tap_sq_q;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q  <= 1'b0;
      d2v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        tracking_q  <= tracking_d;
        d2v_q       <= d2v_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tracking payload and result register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
      prev_x_q   <= prev_x_d;
      prev_y_q   <= prev_y_d;
      pend_dx_q  <= pend_dx_d;
      pend_dy_q  <= pend_dy_d;
      peak_q     <= peak_d;
      d2_q       <= d2_d;
      g_valid_q  <= g_valid_d;
      g_kind_q   <= g_kind_d;
      g_sx_q     <= g_sx_d;
      g_sy_q     <= g_sy_d;
      g_dx_q     <= g_dx_d;
      g_dy_q     <= g_dy_d;
      d_valid_q  <= d_valid_d;
      d_dx_q     <= d_dx_d;
      d_dy_q     <= d_dy_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign gesture_valid_o   = g_valid_q;
  assign gesture_kind_o    = g_kind_q;
  assign gesture_start_x_o = g_sx_q;
  assign gesture_start_y_o = g_sy_q;
  assign gesture_dx_o      = $signed(g_dx_q);
  assign gesture_dy_o      = $signed(g_dy_q);
  assign drag_valid_o      = d_valid_q;
  assign drag_dx_o         = $signed(d_dx_q);
  assign drag_dy_o         = $signed(d_dy_q);

  // A lift ends tracking, so a gesture and a drag never share one result
  a_no_gesture_and_drag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(gesture_valid_o && drag_valid_o))
    else $error("gesture and drag reported in one transaction");

  // Held squared travel only exists while a touch is tracked
  a_d2_only_tracking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2v_q |-> tracking_q)
    else $error("squared travel held without tracking");

  // A frame with a finger down leaves the block tracking
  a_press_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && finger_down_i) |=> tracking_q)
    else $error("finger down did not start or keep tracking");

  // A frame without a finger leaves the block idle
  a_lift_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !finger_down_i) |=> (!tracking_q && !d2v_q))
    else $error("tracking kept after lift");

  // A result without drag carries zero deltas
  a_drag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !drag_valid_o) |-> ((drag_dx_o == '0) && (drag_dy_o == '0)))
    else $error("drag delta nonzero without drag");

endmodule

`default_nettype wire
